// ===== sv/smmm_pkg.sv =====
// shared types and constants for the sample min/max/median core
package smmm_pkg;

    localparam int CAPACITY = 256;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SAMPLE_W = 16;
    localparam int MED_W    = SAMPLE_W + 1;
    localparam int COUNT_W  = 9;
    // neighbor used for the second middle sample
    localparam int SECOND   = (CAPACITY > 1) ? 1 : 0;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [MED_W-1:0]    t_median;
    typedef logic [CNT_W-1:0]           t_count;

    typedef enum logic [0:0] {
        ST_FILL,
        ST_DRAIN
    } t_state;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

endpackage

// ===== sv/smmm_cell.sv =====
// one cell of the sorted insertion chain
module smmm_cell
    import smmm_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_sample    i_sample,
    input  logic       i_occ,
    input  t_sample    i_lower_val,
    input  logic       i_lower_goe,
    input  t_sample    i_upper_val,
    output t_sample    o_val,
    output logic       o_goe
);

    t_sample r_val;
    t_sample n_val;

    // empty or holding a larger value: this cell moves on insert
    assign o_goe = !i_occ || (r_val > i_sample);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.insert) begin
            if (o_goe) begin
                n_val = i_lower_goe ? i_lower_val : i_sample;
            end
        end else if (i_ctrl.shift) begin
            n_val = i_upper_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ===== sv/sample_min_max_median_core.sv =====
// top level: insertion chain with running min/max and median readout
//
// Samples of a set enter one per transfer and are placed into an ascending
// chain of CAPACITY cells; every cell compares the broadcast sample with its
// own value and either keeps it, takes its lower neighbor or takes the new
// sample. Min and max are tracked in running registers. After the sample
// marked last, the chain shifts down (n-1)/2 times, one step per cycle, with
// n the kept count, so the two middle samples reach the bottom cells; the
// result register is then loaded, but not while the previous result still
// waits in that register. The input stalls during that readout. Samples
// arriving with the chain full are dropped and raise the overflow flag. The
// result sits in an output register, so the next set may start while it
// waits for its transfer.
module sample_min_max_median_core
    import smmm_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // sample channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [15:0]        i_temperature,
    input  logic                      i_last_sample,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [15:0]        o_lowest,
    output logic signed [15:0]        o_highest,
    output logic signed [16:0]        o_median_doubled,
    output logic [8:0]                o_sample_count,
    output logic                      o_overflow
);

    t_state     r_state;
    t_state     n_state;
    t_count     r_count;
    t_count     r_steps;
    t_count     w_count_after;
    logic       r_dropped;
    t_sample    r_lo;
    t_sample    r_hi;

    logic       r_out_valid;
    t_sample    r_out_lo;
    t_sample    r_out_hi;
    t_median    r_out_med;
    logic [COUNT_W-1:0] r_out_cnt;
    logic       r_out_ovf;

    t_cell_ctrl w_ctrl;
    t_sample    w_val [CAPACITY];
    logic       w_goe [CAPACITY];
    logic       w_occ [CAPACITY];

    logic       w_accept;
    logic       w_full;
    logic       w_keep;
    logic       w_out_free;
    logic       w_finish;
    t_median    w_med;

    // the chain of cells
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_sample w_lower_val;
            logic    w_lower_goe;
            t_sample w_upper_val;

            assign w_occ[g] = (CNT_W'(g) < r_count);

            if (g == 0) begin : g_bottom
                // bottom cell always takes the sample itself when it moves
                assign w_lower_val = '0;
                assign w_lower_goe = 1'b0;
            end else begin : g_mid
                assign w_lower_val = w_val[g-1];
                assign w_lower_goe = w_goe[g-1];
            end

            if (g == CAPACITY - 1) begin : g_top
                // top cell content is unused after a shift
                assign w_upper_val = w_val[g];
            end else begin : g_below_top
                assign w_upper_val = w_val[g+1];
            end

            smmm_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_sample    (i_temperature),
                .i_occ       (w_occ[g]),
                .i_lower_val (w_lower_val),
                .i_lower_goe (w_lower_goe),
                .i_upper_val (w_upper_val),
                .o_val       (w_val[g]),
                .o_goe       (w_goe[g])
            );
        end
    endgenerate

    assign w_full        = w_occ[CAPACITY-1];
    assign w_accept      = i_valid && !o_stall;
    assign w_keep        = w_accept && !w_full;
    assign w_out_free    = !r_out_valid || !i_stall;
    assign w_count_after = w_keep ? r_count + 1'b1 : r_count;

    // twice the median: bottom cell doubled, or bottom plus next for an even count
    assign w_med = MED_W'(w_val[0])
                 + (r_count[0] ? MED_W'(w_val[0]) : MED_W'(w_val[SECOND]));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (w_accept && i_last_sample) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_steps == '0 && w_out_free) begin
                    n_state = ST_FILL;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall       = 1'b1;
        w_ctrl.insert = 1'b0;
        w_ctrl.shift  = 1'b0;
        w_finish      = 1'b0;
        unique case (r_state)
            ST_FILL: begin
                o_stall       = 1'b0;
                w_ctrl.insert = w_keep;
            end
            ST_DRAIN: begin
                w_ctrl.shift = (r_steps != '0);
                w_finish     = (r_steps == '0) && w_out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_finish) begin
                r_count <= '0;
            end else if (w_keep) begin
                r_count <= w_count_after;
            end

            if (w_finish) begin
                r_dropped <= 1'b0;
            end else if (w_accept && w_full) begin
                r_dropped <= 1'b1;
            end

            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        // shift count that brings the lower middle sample to the bottom cell
        if (w_accept && i_last_sample) begin
            r_steps <= (w_count_after - 1'b1) >> 1;
        end else if (w_ctrl.shift) begin
            r_steps <= r_steps - 1'b1;
        end

        // running extremes of the kept samples
        if (w_keep) begin
            if (r_count == '0 || i_temperature < r_lo) begin
                r_lo <= i_temperature;
            end
            if (r_count == '0 || i_temperature > r_hi) begin
                r_hi <= i_temperature;
            end
        end

        if (w_finish) begin
            r_out_lo  <= r_lo;
            r_out_hi  <= r_hi;
            r_out_med <= w_med;
            r_out_cnt <= COUNT_W'(r_count);
            r_out_ovf <= r_dropped;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_lowest         = r_out_lo;
    assign o_highest        = r_out_hi;
    assign o_median_doubled = r_out_med;
    assign o_sample_count   = r_out_cnt;
    assign o_overflow       = r_out_ovf;

endmodule
